>>> design/lsa_pkg.sv
// ----------------------------------------------------------------------------
// Latency statistics accumulator package
// Shared widths, command codes and the statistics snapshot type.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int unsigned TICK_W          = 32;
  localparam int unsigned TOTAL_W         = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic               accepted;
    logic [TICK_W-1:0]  count;
    logic [TICK_W-1:0]  min_val;
    logic [TICK_W-1:0]  max_val;
    logic [TOTAL_W-1:0] total;
  } stats_t;

endpackage

>>> design/lsa_front.sv
// ----------------------------------------------------------------------------
// Latency statistics front end
// Accepts commands, applies add or clear to the statistics and pushes a
// snapshot of the updated statistics toward the mean divider.
// ----------------------------------------------------------------------------
module lsa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [lsa_pkg::TICK_W-1:0]   sample_ticks,
  output logic                         push_valid,
  input  logic                         push_stall,
  output lsa_pkg::stats_t              push_data
);
  import lsa_pkg::*;

  logic [TICK_W-1:0]  count;
  logic [TICK_W-1:0]  min_val;
  logic [TICK_W-1:0]  max_val;
  logic [TOTAL_W-1:0] total;
  logic [TICK_W-1:0]  count_next;
  logic [TICK_W-1:0]  min_val_next;
  logic [TICK_W-1:0]  max_val_next;
  logic [TOTAL_W-1:0] total_next;
  logic [TOTAL_W:0]   sum_wide;
  logic               refuse;
  logic               ok;
  logic               take;

  assign take       = in_valid && !push_stall;
  assign in_stall   = push_stall;
  assign push_valid = in_valid;

  always_comb begin
    sum_wide     = {1'b0, total} + {{(TOTAL_W + 1 - TICK_W){1'b0}}, sample_ticks};
    refuse       = (cmd == CMD_ADD) && ((&count) || sum_wide[TOTAL_W]);
    count_next   = count;
    min_val_next = min_val;
    max_val_next = max_val;
    total_next   = total;
    ok           = 1'b1;
    if (cmd == CMD_CLEAR) begin
      count_next   = '0;
      min_val_next = '1;
      max_val_next = '0;
      total_next   = '0;
    end else if (refuse) begin
      ok = 1'b0;
    end else begin
      if (sample_ticks < min_val) begin
        min_val_next = sample_ticks;
      end
      if (sample_ticks > max_val) begin
        max_val_next = sample_ticks;
      end
      total_next = sum_wide[TOTAL_W-1:0];
      count_next = count + TICK_W'(1);
    end
  end

  always_comb begin
    push_data.accepted = ok;
    push_data.count    = count_next;
    push_data.min_val  = min_val_next;
    push_data.max_val  = max_val_next;
    push_data.total    = total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      min_val <= '1;
      max_val <= '0;
      total   <= '0;
    end else if (take) begin
      count   <= count_next;
      min_val <= min_val_next;
      max_val <= max_val_next;
      total   <= total_next;
    end
  end

`ifndef ASSERT_OFF
  a_refuse_holds: assert property (@(posedge clk) disable iff (rst)
    take && refuse |=> $stable(count) && $stable(total) && !$past(push_data.accepted))
    else $error("refused add changed the statistics");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    take && (cmd == CMD_CLEAR) |=> (count == '0) && (total == '0) && (&min_val))
    else $error("clear did not empty the statistics");
`endif

endmodule

>>> design/lsa_queue.sv
// ----------------------------------------------------------------------------
// Latency statistics snapshot queue
// Short FIFO of statistics snapshots between front end and divider.
// ----------------------------------------------------------------------------
module lsa_queue #(
  parameter int unsigned DEPTH = lsa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_stall,
  input  lsa_pkg::stats_t push_data,
  output logic            pop_valid,
  input  logic            pop_stall,
  output lsa_pkg::stats_t pop_data
);
  import lsa_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(DEPTH + 1);

  stats_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LVL_W-1:0]   level;
  logic               push;
  logic               pop;

  assign push_stall = (level == LVL_W'(DEPTH));
  assign pop_valid  = (level != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + LVL_W'(1);
      end else if (pop && !push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_level_track: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> level == $past(level) + LVL_W'(1))
    else $error("queue level lost a pushed transaction");
`endif

endmodule

>>> design/lsa_back.sv
// ----------------------------------------------------------------------------
// Latency statistics back end
// Takes one snapshot at a time, forms the mean with a restoring divider at
// one quotient bit per cycle and holds the result in an output register.
// ----------------------------------------------------------------------------
module lsa_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_stall,
  input  lsa_pkg::stats_t              pop_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic [lsa_pkg::TICK_W-1:0]   sample_count,
  output logic [lsa_pkg::TICK_W-1:0]   min_seen,
  output logic [lsa_pkg::TICK_W-1:0]   max_seen,
  output logic [lsa_pkg::TOTAL_W-1:0]  sum_total,
  output logic [lsa_pkg::TICK_W-1:0]   mean_ticks
);
  import lsa_pkg::*;

  localparam int unsigned STEP_W = $clog2(TICK_W);
  localparam logic [1:0]  S_IDLE = 2'd0;
  localparam logic [1:0]  S_RUN  = 2'd1;
  localparam logic [1:0]  S_HOLD = 2'd2;

  logic [1:0]         state;
  stats_t             snap;
  logic [TOTAL_W-1:0] num;
  logic [TOTAL_W-1:0] dshift;
  logic [TICK_W-1:0]  quot;
  logic [STEP_W-1:0]  step;
  logic               load;
  logic               ge;
  logic               out_free;

  assign pop_stall = (state != S_IDLE);
  assign load      = pop_valid && (state == S_IDLE);
  assign ge        = (num >= dshift);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (load) begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (step == STEP_W'(TICK_W - 1)) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap   <= pop_data;
      num    <= pop_data.total;
      dshift <= {1'b0, pop_data.count, {(TOTAL_W - TICK_W - 1){1'b0}}};
      quot   <= '0;
      step   <= '0;
    end else if (state == S_RUN) begin
      if (ge) begin
        num <= num - dshift;
      end
      quot   <= {quot[TICK_W-2:0], ge};
      dshift <= dshift >> 1;
      step   <= step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_HOLD) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_HOLD) && out_free) begin
      accepted     <= snap.accepted;
      sample_count <= snap.count;
      min_seen     <= snap.min_val;
      max_seen     <= snap.max_val;
      sum_total    <= snap.total;
      mean_ticks   <= (snap.count == '0) ? '0 : quot;
    end
  end

`ifndef ASSERT_OFF
  a_out_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_HOLD)
    else $error("result presented before the division finished");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    load |=> (state == S_RUN) && (step == '0))
    else $error("divider did not start on a taken snapshot");
`endif

endmodule

>>> design/latency_statistics_accumulator_core.sv
// ----------------------------------------------------------------------------
// Latency statistics accumulator core
// Running count, minimum, maximum, 64-bit total and truncated mean of
// 32-bit elapsed-tick samples.
// ----------------------------------------------------------------------------
// Each transaction adds one sample (cmd 0) or clears the statistics (cmd 1)
// and returns one result with the updated statistics and the mean. A refused
// add (count full or total overflow) returns accepted 0 and the unchanged
// statistics. The front end updates the statistics in the cycle a transaction
// is taken and queues a snapshot; the back end forms the mean with a
// restoring divider, one quotient bit per cycle, and each result goes
// through the back end as load, 32 divide steps and output load; the back
// end takes no new snapshot until the last result is loaded. The
// front end keeps taking transactions until the snapshot queue is full.
module latency_statistics_accumulator_core #(
  parameter int unsigned QUEUE_DEPTH = lsa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [lsa_pkg::TICK_W-1:0]   sample_ticks,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         accepted,
  output logic [lsa_pkg::TICK_W-1:0]   sample_count,
  output logic [lsa_pkg::TICK_W-1:0]   min_seen,
  output logic [lsa_pkg::TICK_W-1:0]   max_seen,
  output logic [lsa_pkg::TOTAL_W-1:0]  sum_total,
  output logic [lsa_pkg::TICK_W-1:0]   mean_ticks
);
  import lsa_pkg::*;

  logic   push_valid;
  logic   push_stall;
  stats_t push_data;
  logic   pop_valid;
  logic   pop_stall;
  stats_t pop_data;

  lsa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sample_ticks (sample_ticks),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_data    (push_data)
  );

  lsa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  lsa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_stall    (pop_stall),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .sample_count (sample_count),
    .min_seen     (min_seen),
    .max_seen     (max_seen),
    .sum_total    (sum_total),
    .mean_ticks   (mean_ticks)
  );

endmodule

>>> tb/latency_statistics_accumulator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency statistics accumulator core testbench
// Drives add and clear transactions with random idling on both channels,
// predicts count, min, max, total and mean for every transaction and checks
// each result in order, including a long receiver hold-off that fills the
// block and stalls its input.
// ----------------------------------------------------------------------------
module latency_statistics_accumulator_core_tb;
  import lsa_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYCLES = 50;

  typedef struct packed {
    stats_t            stats;
    logic [TICK_W-1:0] mean;
  } stats_result_t;

  typedef enum int {
    TICKS_ANY,
    TICKS_LOW,
    TICKS_HIGH,
    TICKS_EDGE,
    TICKS_MIXED
  } tick_mix_e;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                cmd;
  logic [TICK_W-1:0]   sample_ticks;
  logic                out_valid;
  logic                out_stall;
  logic                accepted;
  logic [TICK_W-1:0]   sample_count;
  logic [TICK_W-1:0]   min_seen;
  logic [TICK_W-1:0]   max_seen;
  logic [TOTAL_W-1:0]  sum_total;
  logic [TICK_W-1:0]   mean_ticks;

  logic [TICK_W-1:0]   stat_count;
  logic [TICK_W-1:0]   stat_min;
  logic [TICK_W-1:0]   stat_max;
  logic [TOTAL_W-1:0]  stat_total;
  stats_result_t       expected_stats[$];

  int                  err_count;
  int                  gap_pct;
  int                  stall_pct;
  int unsigned         hold_req_cnt;
  int unsigned         hold_seen;
  int unsigned         hold_left;

  latency_statistics_accumulator_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sample_ticks (sample_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .accepted     (accepted),
    .sample_count (sample_count),
    .min_seen     (min_seen),
    .max_seen     (max_seen),
    .sum_total    (sum_total),
    .mean_ticks   (mean_ticks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic clear_stats_model();
    stat_count = '0;
    stat_min   = '1;
    stat_max   = '0;
    stat_total = '0;
  endtask

  task automatic update_stats(input logic op, input logic [TICK_W-1:0] ticks);
    stats_result_t      r;
    logic [TOTAL_W-1:0] headroom;
    headroom = {TOTAL_W{1'b1}} - TOTAL_W'(ticks);
    r.stats.accepted = 1'b1;
    if (op == CMD_CLEAR) begin
      clear_stats_model();
    end else if (stat_count == {TICK_W{1'b1}} || stat_total > headroom) begin
      r.stats.accepted = 1'b0;
    end else begin
      if (ticks < stat_min) stat_min = ticks;
      if (ticks > stat_max) stat_max = ticks;
      stat_total = stat_total + TOTAL_W'(ticks);
      stat_count = stat_count + TICK_W'(1);
    end
    r.stats.count   = stat_count;
    r.stats.min_val = stat_min;
    r.stats.max_val = stat_max;
    r.stats.total   = stat_total;
    r.mean = (stat_count == '0) ? '0 : TICK_W'(stat_total / TOTAL_W'(stat_count));
    expected_stats.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [TOTAL_W-1:0] exp_val,
                                 input logic [TOTAL_W-1:0] got_val);
    $display("ERROR %0t: %s expected %h got %h", $realtime, field, exp_val, got_val);
    err_count++;
  endtask

  task automatic check_result();
    stats_result_t e;
    if (expected_stats.size() == 0) begin
      report_mismatch("unexpected result, count", '0, TOTAL_W'(sample_count));
    end else begin
      e = expected_stats.pop_front();
      if (accepted !== e.stats.accepted)
        report_mismatch("accepted", TOTAL_W'(e.stats.accepted), TOTAL_W'(accepted));
      if (sample_count !== e.stats.count)
        report_mismatch("sample_count", TOTAL_W'(e.stats.count), TOTAL_W'(sample_count));
      if (min_seen !== e.stats.min_val)
        report_mismatch("min_seen", TOTAL_W'(e.stats.min_val), TOTAL_W'(min_seen));
      if (max_seen !== e.stats.max_val)
        report_mismatch("max_seen", TOTAL_W'(e.stats.max_val), TOTAL_W'(max_seen));
      if (sum_total !== e.stats.total)
        report_mismatch("sum_total", e.stats.total, sum_total);
      if (mean_ticks !== e.mean)
        report_mismatch("mean_ticks", TOTAL_W'(e.mean), TOTAL_W'(mean_ticks));
    end
  endtask

  // Receiver: check each transaction, stall at random or hold off on request.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
    if (hold_req_cnt != hold_seen) begin
      hold_seen <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input logic op, input logic [TICK_W-1:0] ticks);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= op;
    sample_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_stats(op, ticks);
  endtask

  function automatic logic [TICK_W-1:0] random_ticks(input tick_mix_e mix);
    tick_mix_e m;
    m = (mix == TICKS_MIXED) ? tick_mix_e'($urandom_range(3)) : mix;
    case (m)
      TICKS_LOW:  return TICK_W'($urandom_range(255));
      TICKS_HIGH: return {TICK_W{1'b1}} - TICK_W'($urandom_range(255));
      TICKS_EDGE: return $urandom_range(1) ? {TICK_W{1'b1}} : '0;
      default:    return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    send_item(CMD_CLEAR, '0);
    send_item(CMD_ADD, '0);
    send_item(CMD_ADD, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 32'h0000_0001);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF);
    send_item(CMD_CLEAR, 32'h1234_5678);
    send_item(CMD_ADD, 32'h8000_0000);
    send_item(CMD_ADD, 32'h7FFF_FFFF);
    send_item(CMD_ADD, 32'h5555_5555);
    send_item(CMD_ADD, 32'hAAAA_AAAA);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_ADD, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 32'hFFFF_FFFF);
    send_item(CMD_ADD, 32'hFFFF_FFFE);
    send_item(CMD_ADD, 32'h0000_0003);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_ADD, 32'h0000_0007);
    send_item(CMD_ADD, 32'h0000_0002);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int        sent;
    int        seq_len;
    tick_mix_e mix;
    gap_pct   = send_pct;
    stall_pct = recv_pct;
    sent      = 0;
    while (sent < n_items) begin
      // Most runs start from a clear; the rest keep accumulating on old state.
      if ($urandom_range(3) != 0) begin
        send_item(CMD_CLEAR, $urandom);
        sent++;
      end
      seq_len = $urandom_range(1, 40);
      mix     = tick_mix_e'($urandom_range(4));
      repeat (seq_len) begin
        send_item(CMD_ADD, random_ticks(mix));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure_fill();
    gap_pct   = 0;
    stall_pct = 0;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (10) send_item(CMD_ADD, random_ticks(TICKS_MIXED));
  endtask

  task automatic wait_for_drain();
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (expected_stats.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (expected_stats.size() != 0) begin
      report_mismatch("missing result, count", TOTAL_W'(expected_stats[0].stats.count),
                      '0);
      void'(expected_stats.pop_front());
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_ADD;
    sample_ticks = '0;
    out_stall    = 1'b0;
    err_count    = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    hold_req_cnt = 0;
    hold_seen    = 0;
    hold_left    = 0;
    clear_stats_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(0, 0, 140);
    test_random_traffic(65, 0, 140);
    test_random_traffic(0, 65, 140);
    test_random_traffic(15, 15, 140);
    test_backpressure_fill();
    wait_for_drain();

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
